### hdl/ldf_pkg.sv
// Shared types and constants for the lidar frame deframer.
// No dependencies; every other file in hdl/ uses this package.
`default_nettype none

package ldf_pkg;

  localparam int unsigned POINTS_PER_FRAME_DEF = 16;
  localparam int unsigned QUEUE_DEPTH          = 2;

  localparam logic [7:0] HEAD_FIRST  = 8'hA5;
  localparam logic [7:0] HEAD_SECOND = 8'h5A;

  // One full turn in hundredths of a degree.
  localparam int unsigned FULL_TURN = 36000;

  // Width of the angle fields of a frame and of the quotient the divider makes.
  localparam int unsigned ANGLE_W = 16;

  typedef struct packed {
    logic [15:0] range_mm;
    logic [7:0]  inten;
  } point_t;

  typedef struct packed {
    logic [15:0] speed;
    logic [15:0] start;
    logic [15:0] stop;
  } frame_head_t;

endpackage

`default_nettype wire

### hdl/ldf_front.sv
// Front end: 3P+10 byte sliding window, running checksum and fresh byte count.
// Detects valid frames and hands their fields to the frame queue. Uses ldf_pkg.
`default_nettype none

module ldf_front #(
  parameter int unsigned POINTS_PER_FRAME = ldf_pkg::POINTS_PER_FRAME_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  logic [7:0]                                    byte_in_i,
  input  logic                                          full_i,
  output logic                                          push_o,
  output ldf_pkg::frame_head_t                          head_o,
  output ldf_pkg::point_t [POINTS_PER_FRAME-1:0]        pts_o
);
  import ldf_pkg::*;

  localparam int unsigned FRAME_LEN = 3 * POINTS_PER_FRAME + 10;
  localparam int unsigned FRESH_W   = $clog2(FRAME_LEN + 1);
  localparam logic [FRESH_W-1:0] FRESH_FULL = FRESH_W'(FRAME_LEN);

  logic [7:0]         win_q [FRAME_LEN];
  logic [7:0]         win_d [FRAME_LEN];
  logic [7:0]         sum_q, sum_d;
  logic [FRESH_W-1:0] fresh_q, fresh_inc;
  logic               accept;
  logic               match;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    for (int k = 0; k < FRAME_LEN - 1; k++) begin
      win_d[k] = win_q[k+1];
    end
    win_d[FRAME_LEN-1] = byte_in_i;
  end

  // Sum of the first FRAME_LEN-1 bytes after the shift.
  assign sum_d     = sum_q - win_q[0] + win_q[FRAME_LEN-1];
  assign fresh_inc = (fresh_q == FRESH_FULL) ? fresh_q : fresh_q + 1'b1;

  assign match = (fresh_inc == FRESH_FULL) && (win_d[0] == HEAD_FIRST) &&
                 (win_d[1] == HEAD_SECOND) && (sum_d == win_d[FRAME_LEN-1]);

  assign push_o = accept && match;

  assign head_o.speed = {win_d[3], win_d[4]};
  assign head_o.start = {win_d[5], win_d[6]};
  assign head_o.stop  = {win_d[7 + 3*POINTS_PER_FRAME], win_d[8 + 3*POINTS_PER_FRAME]};

  for (genvar g = 0; g < POINTS_PER_FRAME; g++) begin : g_pts
    assign pts_o[g].range_mm = {win_d[7 + 3*g], win_d[8 + 3*g]};
    assign pts_o[g].inten    = win_d[9 + 3*g];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < FRAME_LEN; k++) begin
        win_q[k] <= '0;
      end
      sum_q   <= '0;
      fresh_q <= '0;
    end else if (accept) begin
      for (int k = 0; k < FRAME_LEN; k++) begin
        win_q[k] <= win_d[k];
      end
      sum_q <= sum_d;
      // consume the frame's bytes on a match
      fresh_q <= match ? '0 : fresh_inc;
    end
  end

  a_consume_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (fresh_q == '0))
    else $error("fresh count not cleared after frame acceptance");

endmodule

`default_nettype wire

### hdl/ldf_frame_fifo.sv
// Short frame queue between the window front end and the point back end.
// Register based, one write and one read port. Uses ldf_pkg only for the default depth.
`default_nettype none

module ldf_frame_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = ldf_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rd_data_o,
  output logic             full_o,
  output logic             not_empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o      = (count_q == CNT_FULL);
  assign not_empty_o = (count_q != '0);
  assign rd_data_o   = mem_q[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && not_empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == CNT_FULL) |-> !push_i)
    else $error("frame pushed into a full queue");

endmodule

`default_nettype wire

### hdl/ldf_back.sv
// Back end: angle span division and per-point emission into the output register.
// Takes frames from ldf_frame_fifo; uses ldf_pkg types and constants.
`default_nettype none

module ldf_back #(
  parameter int unsigned POINTS_PER_FRAME = ldf_pkg::POINTS_PER_FRAME_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   rec_valid_i,
  output logic                                   pop_o,
  input  ldf_pkg::frame_head_t                   head_i,
  input  ldf_pkg::point_t [POINTS_PER_FRAME-1:0] pts_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [15:0]                            distance_mm_o,
  output logic [7:0]                             intensity_o,
  output logic [16:0]                            angle_centideg_o,
  output logic [15:0]                            rotation_speed_o,
  output logic                                   last_of_frame_o,
  output logic                                   scan_complete_o
);
  import ldf_pkg::*;

  localparam int unsigned DIV_INT   = POINTS_PER_FRAME - 1;
  localparam int unsigned DIV_W     = $clog2(POINTS_PER_FRAME);
  localparam int unsigned IDX_W     = $clog2(POINTS_PER_FRAME);
  // Reciprocal scaled so the product gives an exact quotient for any 16-bit span.
  localparam int unsigned DIV_SH    = ANGLE_W + $clog2(DIV_INT);
  localparam int unsigned RECIP_W   = ANGLE_W + 2;
  localparam int unsigned RECIP_INT = ((1 << DIV_SH) + DIV_INT - 1) / DIV_INT;
  localparam logic [RECIP_W-1:0] RECIP    = RECIP_W'(RECIP_INT);
  localparam logic [ANGLE_W-1:0] DIV_A    = ANGLE_W'(DIV_INT);
  localparam logic [DIV_W-1:0] DIVISOR  = DIV_W'(POINTS_PER_FRAME - 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(POINTS_PER_FRAME - 1);
  localparam logic signed [31:0] START_MUL = 32'(POINTS_PER_FRAME - 1);
  localparam logic signed [31:0] DIFF_MUL  = 32'(POINTS_PER_FRAME);
  localparam logic signed [31:0] SCAN_LIM  = 32'(FULL_TURN * (POINTS_PER_FRAME - 1));
  localparam logic signed [17:0] TURN_18   = 18'(FULL_TURN);
  localparam logic signed [18:0] TURN_19   = 19'(FULL_TURN);

  typedef enum logic [2:0] {
    B_IDLE,
    B_DIV,
    B_REM,
    B_FIX,
    B_EMIT
  } bstate_e;

  bstate_e            state_q;
  logic [15:0]        start_q, speed_q;
  logic signed [17:0] diff_q;
  logic               neg_q;
  point_t             pt_q [POINTS_PER_FRAME];
  logic [15:0]        dvd_q;
  logic [ANGLE_W-1:0] quo_q;
  logic [DIV_W-1:0]   rem_q;
  logic signed [18:0] qacc_q, dq_q;
  logic [DIV_W-1:0]   racc_q, dr_q;
  logic [IDX_W-1:0]   idx_q;
  logic               scan_q;
  logic               out_valid_q;

  // Load-time span: stop - start, or through the zero mark.
  logic signed [17:0] diff_w, ndiff_w;
  logic [15:0]        abs_w;

  always_comb begin
    if (head_i.stop > head_i.start) begin
      diff_w = $signed({2'b0, head_i.stop}) - $signed({2'b0, head_i.start});
    end else begin
      diff_w = $signed({2'b0, head_i.stop}) + TURN_18 - $signed({2'b0, head_i.start});
    end
    ndiff_w = -diff_w;
    abs_w   = diff_w[17] ? ndiff_w[15:0] : diff_w[15:0];
  end

  // Span magnitude divided by P-1: reciprocal multiply, then the remainder.
  logic [ANGLE_W+RECIP_W-1:0] mul_w;
  logic [ANGLE_W-1:0]         quo_w, rem_w;

  assign mul_w = dvd_q * RECIP;
  assign quo_w = ANGLE_W'(mul_w >> DIV_SH);
  assign rem_w = dvd_q - quo_q * DIV_A;

  // Floor quotient and nonnegative remainder of the signed span.
  logic [DIV_W-1:0]   ra;
  logic signed [18:0] qa_pos, dq_w;
  logic [DIV_W-1:0]   dr_w;

  assign ra     = rem_q;
  assign qa_pos = $signed({3'b0, quo_q});

  always_comb begin
    if (!neg_q) begin
      dq_w = qa_pos;
      dr_w = ra;
    end else if (ra == '0) begin
      dq_w = -qa_pos;
      dr_w = '0;
    end else begin
      dq_w = -qa_pos - 19'sd1;
      dr_w = DIVISOR - ra;
    end
  end

  logic signed [31:0] lhs;
  assign lhs = $signed({16'b0, start_q}) * START_MUL +
               $signed({{14{diff_q[17]}}, diff_q}) * DIFF_MUL;

  // Per-point angle and accumulator advance.
  logic [DIV_W:0]     rsum, rsum_red;
  logic               wrap;
  logic signed [18:0] qacc_n, ang_raw, ang_fix;

  assign rsum     = {1'b0, racc_q} + {1'b0, dr_q};
  assign wrap     = (rsum >= {1'b0, DIVISOR});
  assign rsum_red = wrap ? rsum - {1'b0, DIVISOR} : rsum;
  assign qacc_n   = qacc_q + dq_q + (wrap ? 19'sd1 : 19'sd0);
  assign ang_raw  = $signed({3'b0, start_q}) + qacc_q;
  assign ang_fix  = (ang_raw > TURN_19) ? ang_raw - TURN_19 : ang_raw;

  logic out_free;
  logic emit;
  assign out_free    = !out_valid_q || out_ready_i;
  assign emit        = (state_q == B_EMIT) && out_free;
  assign pop_o       = (state_q == B_IDLE) && rec_valid_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= B_IDLE;
      start_q          <= '0;
      speed_q          <= '0;
      diff_q           <= '0;
      neg_q            <= 1'b0;
      for (int k = 0; k < POINTS_PER_FRAME; k++) begin
        pt_q[k] <= '0;
      end
      dvd_q            <= '0;
      quo_q            <= '0;
      rem_q            <= '0;
      qacc_q           <= '0;
      dq_q             <= '0;
      racc_q           <= '0;
      dr_q             <= '0;
      idx_q            <= '0;
      scan_q           <= 1'b0;
      out_valid_q      <= 1'b0;
      distance_mm_o    <= '0;
      intensity_o      <= '0;
      angle_centideg_o <= '0;
      rotation_speed_o <= '0;
      last_of_frame_o  <= 1'b0;
      scan_complete_o  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        B_IDLE: begin
          if (rec_valid_i) begin
            start_q <= head_i.start;
            speed_q <= head_i.speed;
            diff_q  <= diff_w;
            neg_q   <= diff_w[17];
            for (int k = 0; k < POINTS_PER_FRAME; k++) begin
              pt_q[k] <= pts_i[k];
            end
            dvd_q   <= abs_w;
            state_q <= B_DIV;
          end
        end
        B_DIV: begin
          quo_q   <= quo_w;
          state_q <= B_REM;
        end
        B_REM: begin
          rem_q   <= rem_w[DIV_W-1:0];
          state_q <= B_FIX;
        end
        B_FIX: begin
          dq_q    <= dq_w;
          dr_q    <= dr_w;
          qacc_q  <= '0;
          racc_q  <= '0;
          idx_q   <= '0;
          scan_q  <= (lhs > SCAN_LIM);
          state_q <= B_EMIT;
        end
        B_EMIT: begin
          if (out_free) begin
            distance_mm_o    <= pt_q[0].range_mm;
            intensity_o      <= pt_q[0].inten;
            angle_centideg_o <= ang_fix[16:0];
            rotation_speed_o <= speed_q;
            last_of_frame_o  <= (idx_q == LAST_IDX);
            scan_complete_o  <= (idx_q == LAST_IDX) && scan_q;
            // advance to the next point
            for (int k = 0; k < POINTS_PER_FRAME - 1; k++) begin
              pt_q[k] <= pt_q[k+1];
            end
            qacc_q <= qacc_n;
            racc_q <= rsum_red[DIV_W-1:0];
            idx_q  <= idx_q + 1'b1;
            if (idx_q == LAST_IDX) begin
              state_q <= B_IDLE;
            end
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  a_scan_on_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && scan_complete_o) |-> last_of_frame_o)
    else $error("scan complete flagged on a point that is not last");

  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_EMIT) |-> (racc_q < DIVISOR))
    else $error("angle remainder out of range");

endmodule

`default_nettype wire

### hdl/lidar_frame_deframer.sv
// Lidar frame deframer: serial bytes in, one point per output transaction.
//
// Input channel: in_valid_i/in_ready_o carry byte_in_i, one byte per
// transaction, one per cycle while in_ready_o is high. The front end keeps a
// 3P+10 byte window (58 at P = 16) with its checksum; a frame is taken when
// the window holds only unconsumed bytes, starts with A5 5A and its 8-bit
// sum matches the last byte. Output channel: out_valid_o/out_ready_i carry
// P points per frame with distance, intensity, interpolated angle, speed and
// end-of-frame flags. A two-entry frame queue sits between the window and
// the point generator. After the byte that completes it, the first point of
// a frame passes through the queue, the load into the back end, a reciprocal
// multiply for the span division, the remainder step, the interpolation
// set-up and the output register. The back end takes a new frame from the
// queue only when idle, after the last point of the previous frame, so the
// span division and the point emission set the frame rate; in_ready_o drops
// only while the queue is full. A stalled receiver holds the output register
// and the back end; bytes keep flowing until the queue fills. Reset clears
// the window, checksum, fresh count, queue and output valid.
// Dependencies: ldf_pkg, ldf_front, ldf_frame_fifo, ldf_back.
`default_nettype none

module lidar_frame_deframer #(
  parameter int unsigned POINTS_PER_FRAME = ldf_pkg::POINTS_PER_FRAME_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] distance_mm_o,
  output logic [7:0]  intensity_o,
  output logic [16:0] angle_centideg_o,
  output logic [15:0] rotation_speed_o,
  output logic        last_of_frame_o,
  output logic        scan_complete_o
);
  import ldf_pkg::*;

  localparam int unsigned REC_W = $bits(frame_head_t) + POINTS_PER_FRAME * $bits(point_t);

  frame_head_t                   head_wr, head_rd;
  point_t [POINTS_PER_FRAME-1:0] pts_wr, pts_rd;
  logic [REC_W-1:0]              rec_wr, rec_rd;
  logic                          push, pop, full, not_empty;

  ldf_front #(
    .POINTS_PER_FRAME (POINTS_PER_FRAME)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .byte_in_i  (byte_in_i),
    .full_i     (full),
    .push_o     (push),
    .head_o     (head_wr),
    .pts_o      (pts_wr)
  );

  assign rec_wr            = {head_wr, pts_wr};
  assign {head_rd, pts_rd} = rec_rd;

  ldf_frame_fifo #(
    .WIDTH (REC_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .wr_data_i   (rec_wr),
    .pop_i       (pop),
    .rd_data_o   (rec_rd),
    .full_o      (full),
    .not_empty_o (not_empty)
  );

  ldf_back #(
    .POINTS_PER_FRAME (POINTS_PER_FRAME)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rec_valid_i      (not_empty),
    .pop_o            (pop),
    .head_i           (head_rd),
    .pts_i            (pts_rd),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .distance_mm_o    (distance_mm_o),
    .intensity_o      (intensity_o),
    .angle_centideg_o (angle_centideg_o),
    .rotation_speed_o (rotation_speed_o),
    .last_of_frame_o  (last_of_frame_o),
    .scan_complete_o  (scan_complete_o)
  );

endmodule

`default_nettype wire
